>>> sv/dfu_download_state_machine_unit_assert.svh
// Assertion macros for the DFU download state machine unit.
`ifndef DFU_DOWNLOAD_STATE_MACHINE_UNIT_ASSERT_SVH
`define DFU_DOWNLOAD_STATE_MACHINE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that pre implies post in the same cycle.
`define DFU_ASSERT_IMPLY(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");
// Check that pre implies post in the following cycle.
`define DFU_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");
`else
`define DFU_ASSERT_IMPLY(lbl, clk, rstn, pre, post)
`define DFU_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

>>> sv/dfu_pkg.sv
// Types and constants shared by the DFU download state machine unit.
package dfu_pkg;

    localparam int unsigned TRANSFER_SIZE = 4096;
    localparam int unsigned WRITE_CHUNK   = 256;
    localparam int unsigned ERASE_BLOCK   = 4096;
    localparam int unsigned IMAGE_OFFSET  = 262144;
    localparam int unsigned FLASH_LIMIT   = (1024 * 1024) + (1024 * 512);
    localparam int unsigned POLL_MS_BUSY     = 5;
    localparam int unsigned POLL_MS_MANIFEST = 1;
    localparam int unsigned POLL_MS_DONE     = 10;

    typedef enum logic [2:0] {
        OP_DNLOAD    = 3'd0,
        OP_POLL      = 3'd1,
        OP_GETSTATUS = 3'd2,
        OP_CLRSTATUS = 3'd3,
        OP_ABORT     = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_DNSYNC    = 3'd1,
        ST_DNBUSY    = 3'd2,
        ST_DNIDLE    = 3'd3,
        ST_MANSYNC   = 3'd4,
        ST_MANIFEST  = 3'd5,
        ST_WAITRESET = 3'd6,
        ST_ERROR     = 3'd7
    } proto_state_t;

    typedef enum logic [1:0] {
        SC_OK    = 2'd0,
        SC_ADDR  = 2'd1,
        SC_STALL = 2'd2,
        SC_WRITE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ERASE = 2'd1,
        PH_PROG  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        LED_IDLE    = 2'd0,
        LED_ERROR   = 2'd1,
        LED_DONE    = 2'd2,
        LED_WRITING = 2'd3
    } led_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_WRITE = 2'd2
    } flash_cmd_t;

    // Register index of the configuration port.
    localparam logic REG_RAM_LOAD_BASE = 1'b0;

endpackage

>>> sv/dfu_download_state_machine_unit.sv
// DFU download state machine unit: request decode, DFU state and flash sequencer.
// A request is held in the input register and then in the result register before
// it is presented. Throughput: one request per cycle while the result channel
// is not stalled; the state update is one add/compare pass.
// Reset (aresetn low, synchronous): DFU idle, status ok, poll timeout 5 ms,
// sequencer idle, RAM load base zero (flash mode), both channels empty.
`include "dfu_download_state_machine_unit_assert.svh"

module dfu_download_state_machine_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [15:0] s_block_number,
    input  logic [15:0] s_block_length,
    input  logic [15:0] s_packet_offset,
    input  logic [15:0] s_packet_length,
    input  logic        s_flash_busy,

    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [1:0]  m_dev_status,
    output logic [2:0]  m_dev_state,
    output logic [3:0]  m_poll_timeout_ms,
    output logic [1:0]  m_led_mode,
    output logic [1:0]  m_flash_command,
    output logic [31:0] m_flash_address,
    output logic [8:0]  m_write_length,
    output logic [12:0] m_buffer_offset,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration register. Word index sits in paddr[2]; the low bits
    // select a byte lane and are ignored.
    // ------------------------------------------------------------------
    logic [31:0] ram_load_base_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & (paddr[2] == dfu_pkg::REG_RAM_LOAD_BASE);
    assign prdata    = (paddr[2] == dfu_pkg::REG_RAM_LOAD_BASE) ? ram_load_base_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_load_base_reg <= 32'd0;
        end else if (cfg_write) begin
            ram_load_base_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Input register. A held request moves on whenever the result register
    // is empty or being drained, so a new request may enter in the same cycle.
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic [2:0]  in_opcode_reg;
    logic [15:0] in_block_number_reg;
    logic [15:0] in_block_length_reg;
    logic [15:0] in_packet_offset_reg;
    logic [15:0] in_packet_length_reg;
    logic        in_flash_busy_reg;
    logic        m_valid_reg;
    logic        proc_fire;
    logic        s_fire;

    assign proc_fire = in_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready   = ~in_valid_reg | proc_fire;
    assign s_fire    = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_opcode_reg        <= s_opcode;
            in_block_number_reg  <= s_block_number;
            in_block_length_reg  <= s_block_length;
            in_packet_offset_reg <= s_packet_offset;
            in_packet_length_reg <= s_packet_length;
            in_flash_busy_reg    <= s_flash_busy;
        end
    end

    // ------------------------------------------------------------------
    // Protocol and sequencer state
    // ------------------------------------------------------------------
    dfu_pkg::proto_state_t state_reg,   state_next;
    dfu_pkg::status_t      status_reg,  status_next;
    dfu_pkg::phase_t       phase_reg,   phase_next;
    logic [3:0]            timeout_reg, timeout_next;
    logic [31:0]           block_address_reg, block_address_next;
    logic [31:0]           write_address_reg, write_address_next;
    logic [12:0]           bytes_left_reg,    bytes_left_next;
    logic [12:0]           chunk_offset_reg,  chunk_offset_next;

    // Per-request decisions handed from the next-state logic to the result logic
    logic accept_flag;
    logic issue_erase;
    logic issue_write;

    // Shared datapath terms
    logic        load_to_ram;
    logic [16:0] packet_end;
    logic [31:0] dl_address;
    logic [8:0]  chunk_len;
    logic [31:0] wr_src_address;
    logic [12:0] wr_src_offset;

    assign load_to_ram = (ram_load_base_reg != 32'd0);
    assign packet_end  = 17'(in_packet_offset_reg) + 17'(in_packet_length_reg);
    assign dl_address  = (load_to_ram ? ram_load_base_reg : 32'(dfu_pkg::IMAGE_OFFSET))
                       + 32'(32'(in_block_number_reg) * 32'(dfu_pkg::TRANSFER_SIZE));

    // The first chunk after the erase phase starts at the block base, offset zero.
    assign wr_src_address = (phase_reg == dfu_pkg::PH_ERASE) ? block_address_reg
                                                             : write_address_reg;
    assign wr_src_offset  = (phase_reg == dfu_pkg::PH_ERASE) ? 13'd0 : chunk_offset_reg;
    assign chunk_len      = (bytes_left_reg < 13'(dfu_pkg::WRITE_CHUNK))
                          ? bytes_left_reg[8:0] : 9'(dfu_pkg::WRITE_CHUNK);

    // Next state: one request decoded per pass
    always_comb begin
        state_next         = state_reg;
        status_next        = status_reg;
        phase_next         = phase_reg;
        timeout_next       = timeout_reg;
        block_address_next = block_address_reg;
        write_address_next = write_address_reg;
        bytes_left_next    = bytes_left_reg;
        chunk_offset_next  = chunk_offset_reg;
        accept_flag        = 1'b0;
        issue_erase        = 1'b0;
        issue_write        = 1'b0;

        case (in_opcode_reg)
            dfu_pkg::OP_DNLOAD: begin
                if ((packet_end > 17'(dfu_pkg::TRANSFER_SIZE)) ||
                    (packet_end > 17'(in_block_length_reg))) begin
                    // Packet overruns the buffer or the block
                    state_next  = dfu_pkg::ST_ERROR;
                    status_next = dfu_pkg::SC_ADDR;
                end else if (packet_end != 17'(in_block_length_reg)) begin
                    // Partial packet: take it, wait for the rest of the block
                    accept_flag = 1'b1;
                end else if (!(state_reg inside {dfu_pkg::ST_IDLE, dfu_pkg::ST_DNIDLE})) begin
                    state_next  = dfu_pkg::ST_ERROR;
                    status_next = dfu_pkg::SC_STALL;
                end else if ((!load_to_ram && in_flash_busy_reg) ||
                             (phase_reg != dfu_pkg::PH_IDLE)) begin
                    state_next  = dfu_pkg::ST_ERROR;
                    status_next = dfu_pkg::SC_WRITE;
                end else if (in_block_length_reg == 16'd0) begin
                    // Zero-length block ends the download
                    state_next  = dfu_pkg::ST_MANSYNC;
                    status_next = dfu_pkg::SC_OK;
                    accept_flag = 1'b1;
                end else begin
                    // Latch the block base even when it is then rejected
                    block_address_next = dl_address;
                    if (!load_to_ram && (dl_address >= 32'(dfu_pkg::FLASH_LIMIT))) begin
                        state_next  = dfu_pkg::ST_ERROR;
                        status_next = dfu_pkg::SC_ADDR;
                    end else begin
                        bytes_left_next = in_block_length_reg[12:0];
                        // Erase only on a sector boundary in flash mode
                        issue_erase = !load_to_ram &&
                            ((dl_address & 32'(dfu_pkg::ERASE_BLOCK - 1)) == 32'd0);
                        phase_next  = dfu_pkg::PH_ERASE;
                        state_next  = dfu_pkg::ST_DNSYNC;
                        status_next = dfu_pkg::SC_OK;
                        accept_flag = 1'b1;
                    end
                end
            end

            dfu_pkg::OP_POLL: begin
                accept_flag = 1'b1;
                if ((state_reg inside {dfu_pkg::ST_DNSYNC, dfu_pkg::ST_DNBUSY}) &&
                    !in_flash_busy_reg) begin
                    case (phase_reg)
                        dfu_pkg::PH_ERASE: begin
                            phase_next  = dfu_pkg::PH_PROG;
                            issue_write = 1'b1;
                        end
                        dfu_pkg::PH_PROG: begin
                            if (bytes_left_reg != 13'd0) begin
                                issue_write = 1'b1;
                            end else begin
                                phase_next = dfu_pkg::PH_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (issue_write) begin
                    // Advance the chunk pointers
                    bytes_left_next    = bytes_left_reg - 13'(chunk_len);
                    write_address_next = wr_src_address + 32'(chunk_len);
                    chunk_offset_next  = wr_src_offset + 13'(chunk_len);
                end
            end

            dfu_pkg::OP_GETSTATUS: begin
                accept_flag = 1'b1;
                case (state_reg)
                    dfu_pkg::ST_DNSYNC, dfu_pkg::ST_DNBUSY: begin
                        state_next   = (phase_reg == dfu_pkg::PH_IDLE) ? dfu_pkg::ST_DNIDLE
                                                                       : dfu_pkg::ST_DNBUSY;
                        status_next  = dfu_pkg::SC_OK;
                        timeout_next = 4'(dfu_pkg::POLL_MS_BUSY);
                    end
                    dfu_pkg::ST_MANSYNC: begin
                        state_next   = dfu_pkg::ST_MANIFEST;
                        status_next  = dfu_pkg::SC_OK;
                        timeout_next = 4'(dfu_pkg::POLL_MS_MANIFEST);
                    end
                    dfu_pkg::ST_MANIFEST: begin
                        state_next   = dfu_pkg::ST_WAITRESET;
                        status_next  = dfu_pkg::SC_OK;
                        timeout_next = 4'(dfu_pkg::POLL_MS_DONE);
                    end
                    dfu_pkg::ST_IDLE: begin
                        timeout_next = 4'(dfu_pkg::POLL_MS_BUSY);
                    end
                    default: begin
                    end
                endcase
            end

            dfu_pkg::OP_CLRSTATUS: begin
                if (state_reg inside {dfu_pkg::ST_ERROR, dfu_pkg::ST_IDLE,
                                      dfu_pkg::ST_WAITRESET}) begin
                    state_next  = dfu_pkg::ST_IDLE;
                    status_next = dfu_pkg::SC_OK;
                    accept_flag = 1'b1;
                end else begin
                    state_next  = dfu_pkg::ST_ERROR;
                    status_next = dfu_pkg::SC_STALL;
                end
            end

            dfu_pkg::OP_ABORT: begin
                // Sequencer phase is left as it is
                state_next  = dfu_pkg::ST_IDLE;
                status_next = dfu_pkg::SC_OK;
                accept_flag = 1'b1;
            end

            default: begin
                // Unused opcodes: drop with no effect
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= dfu_pkg::ST_IDLE;
            status_reg        <= dfu_pkg::SC_OK;
            phase_reg         <= dfu_pkg::PH_IDLE;
            timeout_reg       <= 4'(dfu_pkg::POLL_MS_BUSY);
            block_address_reg <= 32'd0;
            write_address_reg <= 32'd0;
            bytes_left_reg    <= 13'd0;
            chunk_offset_reg  <= 13'd0;
        end else if (proc_fire) begin
            state_reg         <= state_next;
            status_reg        <= status_next;
            phase_reg         <= phase_next;
            timeout_reg       <= timeout_next;
            block_address_reg <= block_address_next;
            write_address_reg <= write_address_next;
            bytes_left_reg    <= bytes_left_next;
            chunk_offset_reg  <= chunk_offset_next;
        end
    end

    // ------------------------------------------------------------------
    // Result fields, from the decisions and the updated state
    // ------------------------------------------------------------------
    dfu_pkg::led_t       led_next;
    dfu_pkg::flash_cmd_t cmd_next;
    logic [31:0]         cmd_address_next;
    logic [8:0]          cmd_length_next;
    logic [12:0]         cmd_offset_next;

    always_comb begin
        if (state_next == dfu_pkg::ST_IDLE) begin
            led_next = dfu_pkg::LED_IDLE;
        end else if (status_next != dfu_pkg::SC_OK) begin
            led_next = dfu_pkg::LED_ERROR;
        end else if (state_next == dfu_pkg::ST_WAITRESET) begin
            led_next = dfu_pkg::LED_DONE;
        end else begin
            led_next = dfu_pkg::LED_WRITING;
        end

        cmd_next         = dfu_pkg::CMD_NONE;
        cmd_address_next = 32'd0;
        cmd_length_next  = 9'd0;
        cmd_offset_next  = 13'd0;
        if (issue_erase) begin
            cmd_next         = dfu_pkg::CMD_ERASE;
            cmd_address_next = dl_address;
        end else if (issue_write) begin
            cmd_next         = dfu_pkg::CMD_WRITE;
            cmd_address_next = wr_src_address;
            cmd_length_next  = chunk_len;
            cmd_offset_next  = wr_src_offset;
        end
    end

    // ------------------------------------------------------------------
    // Result register. Hold while the consumer stalls.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    logic        res_accepted_reg;
    logic [1:0]  res_status_reg;
    logic [2:0]  res_state_reg;
    logic [3:0]  res_timeout_reg;
    logic [1:0]  res_led_reg;
    logic [1:0]  res_cmd_reg;
    logic [31:0] res_address_reg;
    logic [8:0]  res_length_reg;
    logic [12:0] res_offset_reg;

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            res_accepted_reg <= accept_flag;
            res_status_reg   <= status_next;
            res_state_reg    <= state_next;
            res_timeout_reg  <= timeout_next;
            res_led_reg      <= led_next;
            res_cmd_reg      <= cmd_next;
            res_address_reg  <= cmd_address_next;
            res_length_reg   <= cmd_length_next;
            res_offset_reg   <= cmd_offset_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = res_accepted_reg;
    assign m_dev_status      = res_status_reg;
    assign m_dev_state       = res_state_reg;
    assign m_poll_timeout_ms = res_timeout_reg;
    assign m_led_mode        = res_led_reg;
    assign m_flash_command   = res_cmd_reg;
    assign m_flash_address   = res_address_reg;
    assign m_write_length    = res_length_reg;
    assign m_buffer_offset   = res_offset_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic res_write_cmd;
    logic res_length_ok;
    logic res_erase_cmd;
    logic res_erase_ok;

    assign res_write_cmd = m_valid_reg && (res_cmd_reg == dfu_pkg::CMD_WRITE);
    assign res_length_ok = (res_length_reg != 9'd0) &&
                           (res_length_reg <= 9'(dfu_pkg::WRITE_CHUNK));
    assign res_erase_cmd = m_valid_reg && (res_cmd_reg == dfu_pkg::CMD_ERASE);
    assign res_erase_ok  = res_accepted_reg && (res_state_reg == dfu_pkg::ST_DNSYNC);

    // A request leaving the input register always lands in the result register
    `DFU_ASSERT_NEXT(a_proc_lands, aclk, aresetn, proc_fire, m_valid_reg)
    // A write command carries between one and WRITE_CHUNK bytes
    `DFU_ASSERT_IMPLY(a_write_len, aclk, aresetn, res_write_cmd, res_length_ok)
    // An erase only comes from an accepted block start
    `DFU_ASSERT_IMPLY(a_erase_start, aclk, aresetn, res_erase_cmd, res_erase_ok)

endmodule
